### src/tcpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpd_pkg
// Shared types and constants of the two-class priority dispatcher.
// ----------------------------------------------------------------------------
package tcpd_pkg;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_PEEK   = 2'd1;
  localparam logic [1:0] MODE_TAKE   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [2:0] PRIO_MIN        = 3'd1;
  localparam logic [2:0] PRIO_MAX        = 3'd5;
  localparam logic [2:0] THRESHOLD_RESET = 3'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PUSH_RD,
    ST_PUSH_CMP,
    ST_POP_RD,
    ST_POP_L,
    ST_POP_R,
    ST_POP_CMP,
    ST_FIFO_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic push_rd;
    logic push_step;
    logic pop_rd;
    logic pop_l;
    logic pop_r;
    logic pop_step;
    logic fifo_rd;
    logic out_valid;
  } cmd_t;

  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic is_fifo;
    logic push_done;
    logic pop_done;
    logic pop_has_r;
  } status_t;

endpackage
`default_nettype wire

### src/tcpd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpd_stream_if
// Valid/ready channel carrying a packed payload.
// ----------------------------------------------------------------------------
interface tcpd_stream_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/tcpd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpd_ctrl
// Controller state machine sequencing heap sifts and FIFO accesses.
// ----------------------------------------------------------------------------
module tcpd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              out_fire,
  input  wire tcpd_pkg::status_t st,
  output tcpd_pkg::cmd_t         cmd,
  output logic                   busy
);
  import tcpd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_fire) state_nxt = ST_DECODE;
      ST_DECODE: begin
        if (st.is_push) state_nxt = ST_PUSH_CMP;
        else if (st.is_pop) state_nxt = ST_POP_RD;
        else if (st.is_fifo) state_nxt = ST_FIFO_RD;
        else state_nxt = ST_OUT;
      end
      ST_PUSH_RD:  state_nxt = ST_PUSH_CMP;
      ST_PUSH_CMP: state_nxt = st.push_done ? ST_OUT : ST_PUSH_RD;
      ST_POP_RD:   state_nxt = st.pop_done ? ST_OUT : ST_POP_L;
      ST_POP_L:    state_nxt = st.pop_has_r ? ST_POP_R : ST_POP_CMP;
      ST_POP_R:    state_nxt = ST_POP_CMP;
      ST_POP_CMP:  state_nxt = st.pop_done ? ST_OUT : ST_POP_L;
      ST_FIFO_RD:  state_nxt = ST_OUT;
      ST_OUT:      if (out_fire) state_nxt = in_fire ? ST_DECODE : ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE:     begin cmd.load = in_fire; busy = 1'b0; end
      ST_DECODE:   cmd.decode = 1'b1;
      ST_PUSH_RD:  cmd.push_rd = 1'b1;
      ST_PUSH_CMP: cmd.push_step = 1'b1;
      ST_POP_RD:   cmd.pop_rd = 1'b1;
      ST_POP_L:    cmd.pop_l = 1'b1;
      ST_POP_R:    cmd.pop_r = 1'b1;
      ST_POP_CMP:  cmd.pop_step = 1'b1;
      ST_FIFO_RD:  cmd.fifo_rd = 1'b1;
      ST_OUT:      begin cmd.out_valid = 1'b1; cmd.load = in_fire; busy = ~out_fire; end
      default:     cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

### src/tcpd_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcpd_dp
// Datapath: heap and FIFO memories, ticket counter and result register.
// ----------------------------------------------------------------------------
module tcpd_dp #(
  parameter int URGENT_DEPTH = 16,
  parameter int NORMAL_DEPTH = 16,
  parameter int TICKET_BITS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tcpd_pkg::cmd_t    cmd,
  input  wire logic [1:0]        in_mode,
  input  wire logic [2:0]        in_prio,
  input  wire logic [15:0]       in_handle,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_data,
  output tcpd_pkg::status_t      st,
  output logic [1:0]             r_status,
  output logic [15:0]            r_ticket,
  output logic [2:0]             r_prio,
  output logic [15:0]            r_handle,
  output logic                   r_urgent
);
  import tcpd_pkg::*;

  localparam int UA = (URGENT_DEPTH > 1) ? $clog2(URGENT_DEPTH) : 1;
  localparam int NA = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
  localparam int EW = TICKET_BITS + 3 + 16;

  typedef struct packed {
    logic [TICKET_BITS-1:0] tk;
    logic [2:0]             pr;
    logic [15:0]            hd;
  } ent_t;

  function automatic logic above(ent_t a, ent_t b);
    if (a.pr != b.pr) return a.pr > b.pr;
    return a.tk < b.tk;
  endfunction

  logic [EW-1:0] heap_mem [URGENT_DEPTH];
  logic [EW-1:0] fifo_mem [NORMAL_DEPTH];

  logic [2:0]             thr_r;
  logic [UA:0]            ucnt_r;
  logic [NA:0]            fcnt_r;
  logic [NA-1:0]          fhead_r, ftail_r;
  logic [TICKET_BITS-1:0] tick_r;
  logic [1:0]             mode_r;
  ent_t                   e_r;
  logic [UA:0]            i_r, cnt_w;
  ent_t                   rd_r, l_r;
  logic                   urg_r;

  logic [2:0] psat;
  always_comb begin
    psat = in_prio;
    if (in_prio < PRIO_MIN) psat = PRIO_MIN;
    if (in_prio > PRIO_MAX) psat = PRIO_MAX;
  end

  logic u_full, f_full, is_ins, is_srv;
  assign is_ins = (mode_r == MODE_INSERT);
  assign is_srv = (mode_r == MODE_PEEK) || (mode_r == MODE_TAKE);
  assign u_full = ucnt_r >= (UA+1)'(URGENT_DEPTH);
  assign f_full = fcnt_r >= (NA+1)'(NORMAL_DEPTH);

  logic [UA:0] parent, lch, rch;
  assign parent = (i_r - 1'b1) >> 1;
  assign lch = {i_r[UA-1:0], 1'b1};
  assign rch = lch + 1'b1;

  logic pop_go;
  assign pop_go = is_srv && (mode_r == MODE_TAKE) && (ucnt_r != '0);

  assign st.is_push = is_ins && urg_r && !u_full;
  assign st.is_pop = pop_go && (ucnt_r != (UA+1)'(1));
  assign st.is_fifo = is_srv && ((ucnt_r != '0) || (fcnt_r != '0)) && !st.is_pop;
  assign st.push_done = (i_r == '0) || !above(e_r, rd_r);
  assign st.pop_has_r = (rch < cnt_w);
  assign st.pop_done = (lch >= cnt_w) || ((cmd.pop_step) && !above(
                        (st.pop_has_r && above(rd_r, l_r)) ? rd_r : l_r, e_r));

  ent_t best;
  logic [UA:0] best_i;
  always_comb begin
    if (rch < cnt_w && above(rd_r, l_r)) begin
      best = rd_r; best_i = rch;
    end else begin
      best = l_r; best_i = lch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESHOLD_RESET;
      ucnt_r <= '0;
      fcnt_r <= '0;
      fhead_r <= '0;
      ftail_r <= '0;
      tick_r <= TICKET_BITS'(1);
    end else begin
      if (cfg_we) thr_r <= cfg_data;
      if (cmd.load) begin
        mode_r <= in_mode;
        e_r <= '{tk: tick_r, pr: psat, hd: in_handle};
        urg_r <= (psat >= thr_r);
      end
      if (cmd.decode) begin
        r_status <= STATUS_OK;
        r_ticket <= '0; r_prio <= '0; r_handle <= '0; r_urgent <= 1'b0;
        if (is_ins) begin
          r_prio <= e_r.pr; r_handle <= e_r.hd; r_urgent <= urg_r;
          if (urg_r ? u_full : f_full) begin
            r_status <= STATUS_FULL;
          end else begin
            r_ticket <= 16'(e_r.tk);
            tick_r <= tick_r + 1'b1;
            if (urg_r) begin
              i_r <= ucnt_r;
              ucnt_r <= ucnt_r + 1'b1;
              rd_r <= heap_mem[UA'((ucnt_r - 1'b1) >> 1)];
            end else begin
              fifo_mem[ftail_r] <= e_r;
              ftail_r <= (ftail_r == NA'(NORMAL_DEPTH-1)) ? '0 : ftail_r + 1'b1;
              fcnt_r <= fcnt_r + 1'b1;
            end
          end
        end else if (is_srv) begin
          if (ucnt_r != '0) begin
            rd_r <= heap_mem[0];
            r_urgent <= 1'b1;
            i_r <= '0;
            cnt_w <= ucnt_r - 1'b1;
            e_r <= heap_mem[UA'(ucnt_r - 1'b1)];
            if (mode_r == MODE_TAKE) ucnt_r <= ucnt_r - 1'b1;
          end else if (fcnt_r == '0) begin
            r_status <= STATUS_EMPTY;
          end else begin
            rd_r <= fifo_mem[fhead_r];
            if (mode_r == MODE_TAKE) begin
              fhead_r <= (fhead_r == NA'(NORMAL_DEPTH-1)) ? '0 : fhead_r + 1'b1;
              fcnt_r <= fcnt_r - 1'b1;
            end
          end
        end
      end
      if (cmd.fifo_rd || cmd.pop_rd) begin
        r_ticket <= 16'(rd_r.tk); r_prio <= rd_r.pr; r_handle <= rd_r.hd;
        if (cmd.pop_rd && st.pop_done) heap_mem[0] <= e_r;
      end
      if (cmd.push_rd) rd_r <= heap_mem[UA'(parent)];
      if (cmd.push_step) begin
        if (st.push_done) heap_mem[UA'(i_r)] <= e_r;
        else begin
          heap_mem[UA'(i_r)] <= rd_r;
          i_r <= parent;
        end
      end
      if (cmd.pop_l) begin
        l_r <= heap_mem[UA'(lch)];
        rd_r <= heap_mem[UA'(st.pop_has_r ? rch : lch)];
      end
      if (cmd.pop_step) begin
        if (st.pop_done) heap_mem[UA'(i_r)] <= e_r;
        else begin
          heap_mem[UA'(i_r)] <= best;
          i_r <= best_i;
          if ({best_i[UA-1:0], 1'b1} >= cnt_w) heap_mem[UA'(best_i)] <= e_r;
        end
      end
    end
  end
endmodule
`default_nettype wire

### src/two_class_priority_dispatcher_top.sv
`default_nettype none
// Timing from accept to result is set by the heap sift: insert walks up a level
// per parent read and compare, take walks down a level per child reads and compare.
// Throughput: one transaction at a time; the next one is accepted in the cycle
// its result leaves.
// Reset: synchronous active-low rst_n empties both stores, sets the ticket to 1
// and the threshold to 3.
// ----------------------------------------------------------------------------
// two_class_priority_dispatcher_top
// Heap-over-FIFO two-class scheduler with ticketed inserts.
// ----------------------------------------------------------------------------
module two_class_priority_dispatcher_top #(
  parameter int URGENT_DEPTH = 16,
  parameter int NORMAL_DEPTH = 16,
  parameter int TICKET_BITS  = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  tcpd_stream_if.sink   in_ch,
  tcpd_stream_if.source out_ch,
  tcpd_stream_if.sink   cfg_ch
);
  import tcpd_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    busy, in_fire, out_fire;
  logic [1:0] rs; logic [15:0] rt, rh; logic [2:0] rp; logic ru;

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = cmd.out_valid;
  assign out_ch.data = {rs, rt, rp, rh, ru};

  tcpd_ctrl u_ctrl (.clk, .rst_n, .in_fire, .out_fire, .st, .cmd, .busy);

  tcpd_dp #(.URGENT_DEPTH(URGENT_DEPTH), .NORMAL_DEPTH(NORMAL_DEPTH),
            .TICKET_BITS(TICKET_BITS)) u_dp (
    .clk, .rst_n, .cmd,
    .in_mode(in_ch.data[20:19]), .in_prio(in_ch.data[18:16]),
    .in_handle(in_ch.data[15:0]),
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data[2:0]),
    .st, .r_status(rs), .r_ticket(rt), .r_prio(rp), .r_handle(rh), .r_urgent(ru));

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_step |-> !in_ch.ready) else $error("accept during sift");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

### tb/sv/tcpd_dispatch_checker.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcpd_dispatch_checker
// Watches the request, result and threshold channels of the dispatcher.
// It keeps its own heap and FIFO model, predicts one result per request
// and compares every result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tcpd_dispatch_checker
  import tcpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [20:0] in_data,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [37:0] out_data,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_data,
  output int               pending,
  output int               fail_count
);

  localparam int HEAP_DEPTH = 16;
  localparam int QUEUE_DEPTH = 16;

  typedef struct {
    logic [15:0] tk;
    logic [2:0]  pr;
    logic [15:0] hd;
  } entry_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] ticket;
    logic [2:0]  prio;
    logic [15:0] handle;
    logic        urgent;
  } dispatch_t;

  entry_t      heap_mem [HEAP_DEPTH];
  entry_t      fifo_mem [$];
  int          heap_cnt;
  logic [15:0] ticket_ctr;
  logic [2:0]  threshold;
  dispatch_t   expected_dispatch [$];

  assign pending = expected_dispatch.size();

  function automatic bit outranks(entry_t a, entry_t b);
    if (a.pr != b.pr) return a.pr > b.pr;
    return a.tk < b.tk;
  endfunction

  task automatic heap_insert(entry_t e);
    int i;
    int p;
    i = heap_cnt;
    heap_cnt++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!outranks(e, heap_mem[p])) break;
      heap_mem[i] = heap_mem[p];
      i = p;
    end
    heap_mem[i] = e;
  endtask

  task automatic heap_remove_top();
    entry_t last;
    int i;
    int l;
    int best;
    i = 0;
    heap_cnt--;
    if (heap_cnt == 0) return;
    last = heap_mem[heap_cnt];
    forever begin
      l = 2 * i + 1;
      if (l >= heap_cnt) break;
      best = l;
      if (l + 1 < heap_cnt && outranks(heap_mem[l+1], heap_mem[l])) best = l + 1;
      if (!outranks(heap_mem[best], last)) break;
      heap_mem[i] = heap_mem[best];
      i = best;
    end
    heap_mem[i] = last;
  endtask

  task automatic predict_dispatch(logic [1:0] mode, logic [2:0] preq, logic [15:0] hd);
    dispatch_t r;
    entry_t    e;
    logic      urg;
    r = '{default: '0};
    if (mode == MODE_INSERT) begin
      e.pr = (preq < PRIO_MIN) ? PRIO_MIN : (preq > PRIO_MAX) ? PRIO_MAX : preq;
      e.hd = hd;
      e.tk = ticket_ctr;
      urg = (e.pr >= threshold);
      r.prio = e.pr;
      r.handle = hd;
      r.urgent = urg;
      if (urg ? (heap_cnt >= HEAP_DEPTH) : (fifo_mem.size() >= QUEUE_DEPTH)) begin
        r.status = STATUS_FULL;
      end else begin
        if (urg) heap_insert(e);
        else fifo_mem.push_back(e);
        ticket_ctr++;
        r.status = STATUS_OK;
        r.ticket = e.tk;
      end
    end else if (mode == MODE_PEEK || mode == MODE_TAKE) begin
      if (heap_cnt > 0) begin
        e = heap_mem[0];
        if (mode == MODE_TAKE) heap_remove_top();
        r = '{STATUS_OK, e.tk, e.pr, e.hd, 1'b1};
      end else if (fifo_mem.size() > 0) begin
        e = fifo_mem[0];
        if (mode == MODE_TAKE) void'(fifo_mem.pop_front());
        r = '{STATUS_OK, e.tk, e.pr, e.hd, 1'b0};
      end else begin
        r.status = STATUS_EMPTY;
      end
    end
    expected_dispatch.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    dispatch_t got;
    dispatch_t want;
    if (!rst_n) begin
      heap_cnt = 0;
      fifo_mem.delete();
      ticket_ctr = 16'd1;
      threshold = THRESHOLD_RESET;
      expected_dispatch.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (out_valid && out_ready) begin
        got = '{out_data[37:36], out_data[35:20], out_data[19:17], out_data[16:1],
                out_data[0]};
        if (expected_dispatch.size() == 0) begin
          report_mismatch("unexpected transaction", got.ticket, 16'd0);
        end else begin
          want = expected_dispatch.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 16'(got.status), 16'(want.status));
          if (got.ticket !== want.ticket) report_mismatch("ticket", got.ticket, want.ticket);
          if (got.prio !== want.prio)
            report_mismatch("priority", 16'(got.prio), 16'(want.prio));
          if (got.handle !== want.handle) report_mismatch("handle", got.handle, want.handle);
          if (got.urgent !== want.urgent)
            report_mismatch("from_urgent", 16'(got.urgent), 16'(want.urgent));
        end
      end
      if (in_valid && in_ready) predict_dispatch(in_data[20:19], in_data[18:16], in_data[15:0]);
    end
  end

endmodule
`default_nettype wire

### tb/sv/two_class_priority_dispatcher_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// two_class_priority_dispatcher_top_tb
// Drives directed and random insert, peek and take transactions in bursts
// over several threshold settings, stalls the result side, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
module two_class_priority_dispatcher_top_tb;
  import tcpd_pkg::*;

  logic clk;
  logic rst_n;
  int   pending;
  int   fail_count;
  int   burst_left;
  int   stall_style;
  logic [2:0] thresholds [8] = '{3'd0, 3'd5, 3'd1, 3'd7, 3'd4, 3'd2, 3'd6, 3'd3};

  tcpd_stream_if #(.W(21)) in_if ();
  tcpd_stream_if #(.W(38)) out_if ();
  tcpd_stream_if #(.W(3))  cfg_if ();

  two_class_priority_dispatcher_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  tcpd_dispatch_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_data    (in_if.data),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_data   (out_if.data),
    .cfg_valid  (cfg_if.valid),
    .cfg_ready  (cfg_if.ready),
    .cfg_data   (cfg_if.data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    out_if.ready = 1'b0;
    stall_style = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
        0: out_if.ready = 1'b1;
        1: out_if.ready = ($urandom_range(0, 3) != 0);
        2: out_if.ready = 1'($urandom_range(0, 1));
        default: out_if.ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send_request(logic [1:0] mode, logic [2:0] preq, logic [15:0] hd);
    if (burst_left == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_if.valid = 1'b1;
    in_if.data = {mode, preq, hd};
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic drain_and_idle();
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_threshold(logic [2:0] value);
    cfg_if.valid = 1'b1;
    cfg_if.data = value;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic send_random(int take_weight);
    int r;
    logic [1:0] mode;
    r = $urandom_range(0, 99);
    if (r < 3) mode = MODE_UNUSED;
    else if (r < 3 + take_weight) mode = MODE_TAKE;
    else if (r < 13 + take_weight) mode = MODE_PEEK;
    else mode = MODE_INSERT;
    send_request(mode, 3'($urandom_range(0, 7)), 16'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    burst_left = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    send_request(MODE_PEEK, 3'd0, 16'h0000);
    send_request(MODE_TAKE, 3'd0, 16'hffff);
    send_request(MODE_UNUSED, 3'd7, 16'hffff);
    send_request(MODE_INSERT, 3'd0, 16'h0000);
    send_request(MODE_INSERT, 3'd7, 16'hffff);
    send_request(MODE_INSERT, 3'd2, 16'h5a5a);
    send_request(MODE_INSERT, 3'd3, 16'ha5a5);
    send_request(MODE_INSERT, 3'd5, 16'h1234);
    send_request(MODE_INSERT, 3'd6, 16'h4321);
    send_request(MODE_INSERT, 3'd4, 16'h00ff);
    send_request(MODE_INSERT, 3'd1, 16'hff00);
    send_request(MODE_PEEK, 3'd0, 16'h0000);
    repeat (9) send_request(MODE_TAKE, 3'd0, 16'h0000);
    send_request(MODE_PEEK, 3'd0, 16'h0000);
    drain_and_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_threshold(thresholds[ph]);
      repeat (120) send_random(10);
      repeat (60) send_random(55);
      repeat (60) send_random(20);
      drain_and_idle();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
